// ----- hdl/stpg_pkg.sv -----
// Package for the stepper pulse command generator.
// Holds the command character codes, state widths and reset values.
// No dependencies.
`default_nettype none

package stpg_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned HALF_W = 8;
    localparam int unsigned TURN_W = 16;

    // Command characters.
    localparam logic [CHAR_W-1:0] CH_DIR_SET     = 8'h44;  // D
    localparam logic [CHAR_W-1:0] CH_DIR_CLR     = 8'h64;  // d
    localparam logic [CHAR_W-1:0] CH_EN_SET      = 8'h45;  // E
    localparam logic [CHAR_W-1:0] CH_EN_CLR      = 8'h65;  // e
    localparam logic [CHAR_W-1:0] CH_LED_SET     = 8'h4C;  // L
    localparam logic [CHAR_W-1:0] CH_LED_CLR     = 8'h6C;  // l
    localparam logic [CHAR_W-1:0] CH_STEP_ON     = 8'h50;  // P
    localparam logic [CHAR_W-1:0] CH_STEP_OFF    = 8'h70;  // p
    localparam logic [CHAR_W-1:0] CH_TURN_START  = 8'h54;  // T
    localparam logic [CHAR_W-1:0] CH_TURN_CANCEL = 8'h74;  // t
    localparam logic [CHAR_W-1:0] CH_HP_250      = 8'h40;  // @
    localparam logic [CHAR_W-1:0] CH_HP_167      = 8'h23;  // #
    localparam logic [CHAR_W-1:0] CH_HP_125      = 8'h24;  // $
    localparam logic [CHAR_W-1:0] CH_HP_100      = 8'h25;  // %
    localparam logic [CHAR_W-1:0] CH_HP_83       = 8'h5E;  // ^
    localparam logic [CHAR_W-1:0] CH_HP_71       = 8'h26;  // &
    localparam logic [CHAR_W-1:0] CH_HP_63       = 8'h2A;  // *
    localparam logic [3:0]        CH_DIGIT_HI    = 4'h3;
    localparam logic [3:0]        DIGIT_MAX      = 4'd8;

    localparam logic [TURN_W-1:0] STEPS_BASE     = 16'd200;
    localparam logic [TURN_W-1:0] STEPS_RESET    = 16'd1600;
    localparam logic [HALF_W-1:0] HALF_RESET     = 8'd63;

    // Steps per turn for a digit 0..8; 200 << 8 = 51200 still fits 16 bits.
    function automatic logic [TURN_W-1:0] steps_for_digit(input logic [3:0] digit);
        return STEPS_BASE << digit;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/stepper_pulse_command_generator_unit.sv -----
// Stepper pulse command generator: tick/character beats in, output levels out.
// Each result is registered; one beat per cycle while the result is not stalled.
// An input register and a result register bracket one pass of state-update logic,
// so one more beat can wait in the input register while a finished result is stalled.
// Reset: synchronous, active low; clears the pipeline valids and all block state.
// Depends on stpg_pkg.
`default_nettype none

module stepper_pulse_command_generator_unit (
    input  wire  logic                        i_clk,
    input  wire  logic                        i_rst_n,
    input  wire  logic                        i_valid,
    output       logic                        o_stall,
    input  wire  logic                        i_req_type,
    input  wire  logic [stpg_pkg::CHAR_W-1:0] i_char_code,
    output       logic                        o_valid,
    input  wire  logic                        i_stall,
    output       logic                        o_pulse_level,
    output       logic                        o_direction_level,
    output       logic                        o_enable_level,
    output       logic                        o_aux_led_level,
    output       logic                        o_activity_led,
    output       logic                        o_edge_now
);
    import stpg_pkg::*;

    // Input stage.
    logic              r_in_valid;
    logic              r_in_req_type;
    logic [CHAR_W-1:0] r_in_char;

    // Block state.
    logic [HALF_W-1:0] r_half, n_half;
    logic [HALF_W-1:0] r_cd, n_cd;
    logic [TURN_W-1:0] r_steps, n_steps;
    logic [TURN_W-1:0] r_turn_rem, n_turn_rem;
    logic r_turn_active, n_turn_active;
    logic r_stepping, n_stepping;
    logic r_pulse, n_pulse;
    logic r_dir, n_dir;
    logic r_en, n_en;
    logic r_led, n_led;
    logic r_char_seen, n_char_seen;
    logic r_activity, n_activity;
    logic n_edge;

    // Result stage.
    logic r_out_valid;
    logic r_out_edge;

    logic adv;
    logic in_take;
    logic fire;
    logic is_digit;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !adv;
    assign in_take = i_valid && !o_stall;
    assign fire    = r_in_valid && adv;
    assign is_digit = (r_in_char[7:4] == CH_DIGIT_HI) && (r_in_char[3:0] <= DIGIT_MAX);

    always_comb begin
        n_half        = r_half;
        n_cd          = r_cd;
        n_steps       = r_steps;
        n_turn_rem    = r_turn_rem;
        n_turn_active = r_turn_active;
        n_stepping    = r_stepping;
        n_pulse       = r_pulse;
        n_dir         = r_dir;
        n_en          = r_en;
        n_led         = r_led;
        n_char_seen   = r_char_seen;
        n_activity    = r_activity;
        n_edge        = 1'b0;
        if (r_in_req_type) begin
            n_char_seen = 1'b1;
            if (is_digit) begin
                n_steps = steps_for_digit(r_in_char[3:0]);
            end
            unique case (r_in_char)
                CH_DIR_SET:     n_dir = 1'b1;
                CH_DIR_CLR:     n_dir = 1'b0;
                CH_EN_SET:      n_en  = 1'b1;
                CH_EN_CLR:      n_en  = 1'b0;
                CH_LED_SET:     n_led = 1'b1;
                CH_LED_CLR:     n_led = 1'b0;
                CH_STEP_ON:     n_stepping = 1'b1;
                CH_STEP_OFF:    n_stepping = 1'b0;
                CH_TURN_CANCEL: begin
                    n_turn_active = 1'b0;
                    n_stepping    = 1'b0;
                    n_turn_rem    = '0;
                end
                CH_TURN_START: begin
                    if (!r_turn_active) begin
                        n_turn_active = 1'b1;
                        n_turn_rem    = r_steps;
                    end
                end
                CH_HP_250: n_half = 8'd250;
                CH_HP_167: n_half = 8'd167;
                CH_HP_125: n_half = 8'd125;
                CH_HP_100: n_half = 8'd100;
                CH_HP_83:  n_half = 8'd83;
                CH_HP_71:  n_half = 8'd71;
                CH_HP_63:  n_half = 8'd63;
                default: ;
            endcase
        end else if (r_cd <= 8'd1) begin
            // A countdown of zero also counts as an edge.
            n_edge = 1'b1;
            n_cd   = r_half;
            if (r_turn_active) begin
                if (r_turn_rem == '0) begin
                    n_turn_active = 1'b0;
                    n_stepping    = 1'b0;
                end else begin
                    n_stepping = 1'b1;
                end
            end
            n_pulse = !r_pulse && n_stepping;
            if (r_turn_rem != '0) begin
                n_turn_rem = r_turn_rem - 16'd1;
            end
            n_activity  = r_char_seen;
            n_char_seen = 1'b0;
        end else begin
            n_cd = r_cd - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req_type <= i_req_type;
            r_in_char     <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half        <= HALF_RESET;
            r_cd          <= HALF_RESET;
            r_steps       <= STEPS_RESET;
            r_turn_rem    <= '0;
            r_turn_active <= 1'b0;
            r_stepping    <= 1'b0;
            r_pulse       <= 1'b0;
            r_dir         <= 1'b0;
            r_en          <= 1'b0;
            r_led         <= 1'b0;
            r_char_seen   <= 1'b0;
            r_activity    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_half        <= n_half;
                r_cd          <= n_cd;
                r_steps       <= n_steps;
                r_turn_rem    <= n_turn_rem;
                r_turn_active <= n_turn_active;
                r_stepping    <= n_stepping;
                r_pulse       <= n_pulse;
                r_dir         <= n_dir;
                r_en          <= n_en;
                r_led         <= n_led;
                r_char_seen   <= n_char_seen;
                r_activity    <= n_activity;
            end
        end
    end

    // The level outputs read the state registers, which change only when a
    // new result is loaded, so they hold steady while the result is stalled.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_edge <= n_edge;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_pulse_level     = r_pulse;
    assign o_direction_level = r_dir;
    assign o_enable_level    = r_en;
    assign o_aux_led_level   = r_led;
    assign o_activity_led    = r_activity;
    assign o_edge_now        = r_out_edge;

endmodule

`default_nettype wire

// ----- hdl/stpg_checker.sv -----
// Port-level checks for the stepper pulse command generator.
// Bound to stepper_pulse_command_generator_unit; no package dependency.
`default_nettype none

module stpg_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_pulse_level,
    input wire logic o_activity_led,
    input wire logic o_edge_now
);
    logic r_have_last;
    logic r_last_pulse;
    logic r_last_activity;
    logic out_fire;

    assign out_fire = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
        end else if (out_fire) begin
            r_have_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_last_pulse    <= o_pulse_level;
            r_last_activity <= o_activity_led;
        end
    end

    // The input side only backs up when a result is already waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stall raised with no result pending");

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Pulse and activity levels move only on beats that carry an edge.
    a_pulse_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_have_last && !o_edge_now |-> o_pulse_level == r_last_pulse)
        else $error("pulse level changed without an edge");

    a_activity_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_have_last && !o_edge_now |-> o_activity_led == r_last_activity)
        else $error("activity level changed without an edge");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pulse_level) && $stable(o_edge_now))
        else $error("stalled result changed");

endmodule

bind stepper_pulse_command_generator_unit stpg_checker u_stpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pulse_level  (o_pulse_level),
    .o_activity_led (o_activity_led),
    .o_edge_now     (o_edge_now)
);

`default_nettype wire
